// ----- design/mf3_pkg.sv -----
// shared constants, types and median helpers for the 3x3 median filter
package mf3_pkg;

    localparam int MAX_SIDE = 1024;
    localparam int ADDR_W = $clog2(MAX_SIDE);
    localparam int SIDE_W = 11;
    localparam int PIX_W = 8;
    localparam int WIN = 3;
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
    localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

    // result kinds, in emission order
    localparam logic [1:0] K_MAIN = 2'd0;
    localparam logic [1:0] K_RIGHT = 2'd1;
    localparam logic [1:0] K_BOTTOM = 2'd2;
    localparam logic [1:0] K_CORNER = 2'd3;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [ADDR_W-1:0] t_pos;
    typedef logic [WIN-1:0][PIX_W-1:0] t_column;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix min3(input t_pix a, input t_pix b, input t_pix c);
        return min2(min2(a, b), c);
    endfunction

    function automatic t_pix max3(input t_pix a, input t_pix b, input t_pix c);
        return max2(max2(a, b), c);
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // columns hold rows top, middle, bottom
    function automatic t_pix median9(input t_column l, input t_column m, input t_column r);
        t_pix lo [WIN];
        t_pix md [WIN];
        t_pix hi [WIN];
        for (int i = 0; i < WIN; i++) begin
            lo[i] = min3(l[i], m[i], r[i]);
            md[i] = med3(l[i], m[i], r[i]);
            hi[i] = max3(l[i], m[i], r[i]);
        end
        return med3(max3(lo[0], lo[1], lo[2]), med3(md[0], md[1], md[2]),
                    min3(hi[0], hi[1], hi[2]));
    endfunction

endpackage

// ----- design/median_filter_3x3_clamped.sv -----
// 3x3 median filter with edge replication over a square raster-order image
//
// Input channel: i_valid / o_stall carry one 8-bit pixel per request, raster
// order. Output channel: o_valid / i_stall carry median, column, row and a
// last flag marking the final result caused by one input pixel.
// Config channel: i_cfg_valid / o_cfg_ready write the image side (2..1024,
// values outside act as the nearest bound); a write restarts the frame.
// An input pixel at (c, r) yields the filtered pixel (c-1, r-1); at the right
// edge and on the bottom row it yields up to four results in raster order.
// The first result of an accepted pixel passes the input register with line-store
// read, the result staging register and the output register.
// Throughput is one pixel per cycle while no stall holds the flow; a pixel with
// several results holds the staging register until its last result is emitted,
// which stalls the input meanwhile. Line stores are one 1024 x 16 memory, read
// and written once per cycle at different columns.
// Reset (synchronous, active low) empties the pipeline and starts a frame at
// column 0, row 0 with side 256. While i_stall is high the output register
// holds its result, and the input stalls once the staging register is full.
module median_filter_3x3_clamped (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mf3_pkg::PIX_W-1:0]         i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [mf3_pkg::PIX_W-1:0]         o_median,
    output logic [mf3_pkg::ADDR_W-1:0]        o_out_col,
    output logic [mf3_pkg::ADDR_W-1:0]        o_out_row,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mf3_pkg::SIDE_W-1:0]        i_cfg_data
);

    // configuration and frame position
    logic [mf3_pkg::SIDE_W-1:0] r_side;
    logic [mf3_pkg::SIDE_W-1:0] w_side_eff;
    mf3_pkg::t_pos              w_s_last;
    mf3_pkg::t_pos              r_col;
    mf3_pkg::t_pos              r_row;

    // line stores: [15:8] older row, [7:0] newer row
    logic [2*mf3_pkg::PIX_W-1:0] r_mem [mf3_pkg::MAX_SIDE];
    logic [2*mf3_pkg::PIX_W-1:0] r_rd;

    // input stage
    logic                r_a_valid;
    mf3_pkg::t_pix       r_a_pix;
    mf3_pkg::t_pos       r_a_col;
    mf3_pkg::t_pos       r_a_row;

    // window
    mf3_pkg::t_column    r_win_l;
    mf3_pkg::t_column    r_win_m;
    mf3_pkg::t_column    w_cur;
    mf3_pkg::t_column    w_left;
    mf3_pkg::t_column    w_mid;
    logic [3:0]          w_mask;

    // result staging
    logic                r_e_valid;
    logic [3:0]          r_e_mask;
    mf3_pkg::t_column    r_e_l;
    mf3_pkg::t_column    r_e_m;
    mf3_pkg::t_column    r_e_r;
    mf3_pkg::t_pos       r_e_col;
    mf3_pkg::t_pos       r_e_row;
    logic [1:0]          w_kind;
    logic [3:0]          n_e_mask;
    mf3_pkg::t_column    w_s0;
    mf3_pkg::t_column    w_s1;
    mf3_pkg::t_column    w_s2;
    mf3_pkg::t_column    w_q0;
    mf3_pkg::t_column    w_q1;
    mf3_pkg::t_column    w_q2;

    // output register
    logic                r_o_valid;
    mf3_pkg::t_pix       r_o_median;
    mf3_pkg::t_pos       r_o_col;
    mf3_pkg::t_pos       r_o_row;
    logic                r_o_last;

    logic w_in_acc;
    logic w_cfg_wr;
    logic w_o_take;
    logic w_emit;
    logic w_e_free;
    logic w_commit;

    always_comb begin
        if (r_side < mf3_pkg::SIDE_MIN) begin
            w_side_eff = mf3_pkg::SIDE_MIN;
        end else if (r_side > mf3_pkg::SIDE_MAX) begin
            w_side_eff = mf3_pkg::SIDE_MAX;
        end else begin
            w_side_eff = r_side;
        end
    end
    assign w_s_last = mf3_pkg::ADDR_W'(w_side_eff - mf3_pkg::SIDE_W'(1));

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;

    // current column of the window: top, middle, bottom
    always_comb begin
        if (r_a_row == '0) begin
            w_cur[0] = r_a_pix;
            w_cur[1] = r_a_pix;
        end else begin
            w_cur[1] = r_rd[mf3_pkg::PIX_W-1:0];
            w_cur[0] = (r_a_row >= mf3_pkg::ADDR_W'(2)) ?
                       r_rd[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W] : r_rd[mf3_pkg::PIX_W-1:0];
        end
        w_cur[2] = r_a_pix;
    end
    assign w_left = (r_a_col == '0) ? w_cur : r_win_l;
    assign w_mid  = (r_a_col == '0) ? w_cur : r_win_m;

    always_comb begin
        w_mask = '0;
        w_mask[mf3_pkg::K_MAIN]   = (r_a_row != '0) && (r_a_col != '0);
        w_mask[mf3_pkg::K_RIGHT]  = w_mask[mf3_pkg::K_MAIN] && (r_a_col == w_s_last);
        w_mask[mf3_pkg::K_BOTTOM] = w_mask[mf3_pkg::K_MAIN] && (r_a_row == w_s_last);
        w_mask[mf3_pkg::K_CORNER] = w_mask[mf3_pkg::K_RIGHT] && w_mask[mf3_pkg::K_BOTTOM];
    end

    // pick the next pending result
    always_comb begin
        if (r_e_mask[mf3_pkg::K_MAIN]) begin
            w_kind = mf3_pkg::K_MAIN;
        end else if (r_e_mask[mf3_pkg::K_RIGHT]) begin
            w_kind = mf3_pkg::K_RIGHT;
        end else if (r_e_mask[mf3_pkg::K_BOTTOM]) begin
            w_kind = mf3_pkg::K_BOTTOM;
        end else begin
            w_kind = mf3_pkg::K_CORNER;
        end
        n_e_mask = r_e_mask;
        n_e_mask[w_kind] = 1'b0;
    end

    // right-edge kinds shift columns, bottom kinds clamp rows
    assign w_s0 = w_kind[0] ? r_e_m : r_e_l;
    assign w_s1 = w_kind[0] ? r_e_r : r_e_m;
    assign w_s2 = r_e_r;

    always_comb begin
        w_q0 = w_s0;
        w_q1 = w_s1;
        w_q2 = w_s2;
        if (w_kind[1]) begin
            w_q0[0] = w_s0[1];
            w_q0[1] = w_s0[2];
            w_q1[0] = w_s1[1];
            w_q1[1] = w_s1[2];
            w_q2[0] = w_s2[1];
            w_q2[1] = w_s2[2];
        end
    end

    assign w_o_take = !r_o_valid || !i_stall;
    assign w_emit   = r_e_valid && w_o_take;
    assign w_e_free = !r_e_valid || (w_emit && (n_e_mask == '0));
    assign w_commit = r_a_valid && ((w_mask == '0) || w_e_free);
    assign o_stall  = r_a_valid && !w_commit;
    assign w_in_acc = i_valid && !o_stall;

    // line store memory
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd <= r_mem[r_col];
        end
        if (w_commit) begin
            r_mem[r_a_col] <= {r_rd[mf3_pkg::PIX_W-1:0], r_a_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= mf3_pkg::SIDE_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_e_mask  <= '0;
            r_o_valid <= 1'b0;
            r_win_l   <= '0;
            r_win_m   <= '0;
        end else begin
            if (w_cfg_wr) begin
                r_side <= i_cfg_data;
                r_col  <= '0;
                r_row  <= '0;
            end else if (w_in_acc) begin
                if (r_col == w_s_last) begin
                    r_col <= '0;
                    r_row <= (r_row == w_s_last) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end

            if (w_in_acc) begin
                r_a_valid <= 1'b1;
            end else if (w_commit) begin
                r_a_valid <= 1'b0;
            end

            if (w_commit) begin
                r_win_l <= w_mid;
                r_win_m <= w_cur;
            end

            if (w_commit && (w_mask != '0)) begin
                r_e_valid <= 1'b1;
                r_e_mask  <= w_mask;
            end else if (w_emit) begin
                r_e_valid <= (n_e_mask != '0);
                r_e_mask  <= n_e_mask;
            end

            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (w_o_take) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_pix <= i_pixel;
            r_a_col <= r_col;
            r_a_row <= r_row;
        end
        if (w_commit && (w_mask != '0)) begin
            r_e_l   <= w_left;
            r_e_m   <= w_mid;
            r_e_r   <= w_cur;
            r_e_col <= r_a_col;
            r_e_row <= r_a_row;
        end
        if (w_emit) begin
            r_o_median <= mf3_pkg::median9(w_q0, w_q1, w_q2);
            r_o_col    <= w_kind[0] ? r_e_col : r_e_col - 1'b1;
            r_o_row    <= w_kind[1] ? r_e_row : r_e_row - 1'b1;
            r_o_last   <= (n_e_mask == '0);
        end
    end

    assign o_valid   = r_o_valid;
    assign o_median  = r_o_median;
    assign o_out_col = r_o_col;
    assign o_out_row = r_o_row;
    assign o_last    = r_o_last;

    // staging register never holds an item without pending results
    a_e_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_e_mask != '0))
        else $error("staging register valid with no pending results");

    // input stalls only while the input register is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && !w_commit && r_e_valid))
        else $error("input stalled without a blocked item");

    // a side write restarts the frame
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> ((r_col == '0) && (r_row == '0)))
        else $error("frame position not cleared by side write");

    // a result that needs the staging register is only committed when it is free
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (w_mask != '0) && r_e_valid) |-> (w_emit && (n_e_mask == '0)))
        else $error("staging register overwritten with results pending");

endmodule
